// ----- sv/rgm_pkg.sv -----
`timescale 1ns / 1ps
package rgm_pkg;
  localparam int MaxWidth = 1024;
  localparam int CordicSteps = 18;
  localparam int AccW = 23;
  localparam int VecW = 28;
  localparam int SqW = 34;
  localparam logic [AccW-1:0] HalfPiAcc = 23'd524288;
  localparam int RegWidth = 0;
  localparam int RegHeight = 1;

  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [11:0] row;
    logic [9:0] col;
    logic done;
  } grad_t;

  function automatic logic [AccW-1:0] atan_lut(input logic [4:0] k);
    logic [AccW-1:0] v;
    case (k)
      5'd0: v = 23'd262144;
      5'd1: v = 23'd154753;
      5'd2: v = 23'd81767;
      5'd3: v = 23'd41506;
      5'd4: v = 23'd20834;
      5'd5: v = 23'd10427;
      5'd6: v = 23'd5215;
      5'd7: v = 23'd2608;
      5'd8: v = 23'd1304;
      5'd9: v = 23'd652;
      5'd10: v = 23'd326;
      5'd11: v = 23'd163;
      5'd12: v = 23'd81;
      5'd13: v = 23'd41;
      5'd14: v = 23'd20;
      5'd15: v = 23'd10;
      5'd16: v = 23'd5;
      5'd17: v = 23'd3;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

// ----- sv/rgb_gradient_magnitude_orientation.sv -----
`timescale 1ns / 1ps
// A pixel's result passes the line stores and the queue, then the back end,
// where a 17 step square root runs beside the 18 step CORDIC. The back end
// takes no new item until its result has been accepted. Pixels that make no
// result pass at one per cycle until two gradient items wait in the queue
// between front and back end.
// Reset (synchronous, rst high) clears counters, delays and the queue.
module rgb_gradient_magnitude_orientation (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [0:0] cfg_index,
  input  logic [11:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic out_valid,
  input  logic out_stall,
  output logic [16:0] magnitude,
  output logic signed [15:0] angle,
  output logic [11:0] out_row,
  output logic [9:0] out_col,
  output logic frame_done
);
  // The front end converts to gray, keeps the line stores and queues
  // gradient items; the back end computes magnitude and angle per item.
  logic q_valid, q_stall;
  rgm_pkg::grad_t q_data;

  rgm_front u_front (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .in_valid, .in_stall,
    .red, .green, .blue, .q_valid, .q_stall, .q_data
  );

  rgm_back u_back (
    .clk, .rst, .q_valid, .q_stall, .q_data, .out_valid, .out_stall,
    .magnitude, .angle, .out_row, .out_col, .frame_done
  );
endmodule

// ----- sv/rgm_front.sv -----
`timescale 1ns / 1ps
module rgm_front (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [0:0] cfg_index,
  input  logic [11:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  output logic q_valid,
  input  logic q_stall,
  output rgm_pkg::grad_t q_data
);
  localparam int AW = $clog2(rgm_pkg::MaxWidth);
  localparam int QD = 4;

  logic [10:0] width_reg;
  logic [11:0] height_reg;
  logic [AW-1:0] wclamp;
  logic [11:0] hclamp;
  logic [12:0] wc;
  logic [12:0] row_counter;
  logic [12:0] col_counter;
  logic [15:0] older_mem [rgm_pkg::MaxWidth];
  logic [15:0] newer_mem [rgm_pkg::MaxWidth];
  logic [15:0] cur_d0, cur_d1, old_d0, old_d1;
  logic [15:0] old_val, mid_val, gray_s;
  logic [12:0] row1, col1, row_n, col_n;
  logic s1_valid, s1_emit, s1_done;
  logic [11:0] s1_row;
  logic [9:0] s1_col;
  logic [12:0] s1_colx;
  rgm_pkg::grad_t qmem [QD];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic take, push, pop;
  logic [15:0] gray;
  logic [12:0] wlim;

  always_comb begin
    wlim = {2'b0, width_reg};
    if (wlim < 13'd3) wlim = 13'd3;
    if (wlim > 13'(rgm_pkg::MaxWidth)) wlim = 13'(rgm_pkg::MaxWidth);
    wc = wlim;
    wclamp = AW'(wlim - 13'd1);
    hclamp = (height_reg < 12'd3) ? 12'd3 : height_reg;
  end

  // Stage 0 updates counters and reads the line stores; s1 writes them back.
  assign in_stall = (cnt >= 3'd2);
  assign take = in_valid && !in_stall;
  assign gray = 16'(16'd77 * red + 16'd150 * green + 16'd29 * blue);

  always_comb begin
    row1 = row_counter;
    col1 = col_counter;
    if (col1 >= wc) begin
      col1 = '0;
      row1 = row1 + 13'd1;
    end
    if (row1 >= {1'b0, hclamp}) row1 = '0;
    col_n = col1 + 13'd1;
    row_n = row1;
    if (col_n >= wc) begin
      col_n = '0;
      row_n = row1 + 13'd1;
      if (row_n >= {1'b0, hclamp}) row_n = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      old_val <= older_mem[col1[AW-1:0]];
      mid_val <= newer_mem[col1[AW-1:0]];
      gray_s <= gray;
      s1_colx <= col1;
      s1_row <= 12'(row1 - 13'd2);
      s1_col <= 10'(col1 - 13'd2);
      s1_emit <= (row1 >= 13'd2) && (col1 >= 13'd2);
      s1_done <= (row1 == {1'b0, hclamp} - 13'd1) && (col1 == 13'(wclamp));
    end
    if (s1_valid) begin
      older_mem[s1_colx[AW-1:0]] <= mid_val;
      newer_mem[s1_colx[AW-1:0]] <= gray_s;
    end
  end

  assign push = s1_valid && s1_emit;
  assign pop = q_valid && !q_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= 11'd1024;
      height_reg <= 12'd480;
      row_counter <= '0;
      col_counter <= '0;
      s1_valid <= 1'b0;
      cur_d0 <= '0; cur_d1 <= '0; old_d0 <= '0; old_d1 <= '0;
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == 1'(rgm_pkg::RegWidth)) width_reg <= cfg_data[10:0];
        else height_reg <= cfg_data;
      end
      s1_valid <= take;
      if (take) begin
        row_counter <= row_n;
        col_counter <= col_n;
      end
      if (s1_valid) begin
        old_d1 <= old_d0;
        old_d0 <= old_val;
        cur_d1 <= cur_d0;
        cur_d0 <= gray_s;
      end
      if (push) wp <= wp + 2'd1;
      if (pop) rp <= rp + 2'd1;
      cnt <= cnt + {2'b0, push} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wp].dx <= $signed({1'b0, old_val}) - $signed({1'b0, old_d1});
      qmem[wp].dy <= $signed({1'b0, old_d1}) - $signed({1'b0, cur_d1});
      qmem[wp].row <= s1_row;
      qmem[wp].col <= s1_col;
      qmem[wp].done <= s1_done;
    end
  end

  assign q_valid = (cnt != 3'd0);
  assign q_data = qmem[rp];
endmodule

// ----- sv/rgm_back.sv -----
`timescale 1ns / 1ps
module rgm_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_stall,
  input  rgm_pkg::grad_t q_data,
  output logic out_valid,
  input  logic out_stall,
  output logic [16:0] magnitude,
  output logic signed [15:0] angle,
  output logic [11:0] out_row,
  output logic [9:0] out_col,
  output logic frame_done
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SQ = 2'd1;
  localparam logic [1:0] S_RUN = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state;
  logic [4:0] k;
  rgm_pkg::grad_t cur;
  logic [rgm_pkg::SqW-1:0] rem, res, bitv;
  logic [33:0] p1, p2;
  logic signed [rgm_pkg::VecW-1:0] x, y, xs, ys;
  logic signed [rgm_pkg::AccW-1:0] acc, accr;
  logic special;
  logic [15:0] spec_ang;

  assign q_stall = (state != S_IDLE);
  assign xs = x >>> k;
  assign ys = y >>> k;
  assign accr = acc + 23'sd16;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) begin
          cur <= q_data;
          p1 <= 34'(q_data.dx * q_data.dx);
          p2 <= 34'(q_data.dy * q_data.dy);
          state <= S_SQ;
        end
        S_SQ: begin
          rem <= p1 + p2;
          res <= '0;
          bitv <= 34'h1 << 32;
          k <= '0;
          special <= (cur.dx == 0) || (cur.dy == 0);
          if (cur.dx == 0) spec_ang <= (cur.dy >= 0) ? 16'h0000 : 16'h8000;
          else spec_ang <= (cur.dx > 0) ? 16'h4000 : 16'hC000;
          if (cur.dy < 0) begin
            if (cur.dx >= 0) begin
              x <= 28'(cur.dx) <<< 8; y <= -(28'(cur.dy) <<< 8);
              acc <= rgm_pkg::HalfPiAcc;
            end else begin
              x <= -(28'(cur.dx) <<< 8); y <= 28'(cur.dy) <<< 8;
              acc <= -rgm_pkg::HalfPiAcc;
            end
          end else begin
            x <= 28'(cur.dy) <<< 8; y <= 28'(cur.dx) <<< 8; acc <= '0;
          end
          state <= S_RUN;
        end
        S_RUN: begin
          if (bitv != 0) begin
            if (rem >= res + bitv) begin
              rem <= rem - (res + bitv);
              res <= (res >> 1) + bitv;
            end else res <= res >> 1;
            bitv <= bitv >> 2;
          end
          if (k < 5'(rgm_pkg::CordicSteps)) begin
            if (y >= 0) begin
              x <= x + ys; y <= y - xs; acc <= acc + rgm_pkg::atan_lut(k);
            end else begin
              x <= x - ys; y <= y + xs; acc <= acc - rgm_pkg::atan_lut(k);
            end
            k <= k + 5'd1;
          end
          if (bitv == 0 && k == 5'(rgm_pkg::CordicSteps)) begin
            magnitude <= res[16:0];
            angle <= special ? spec_ang : accr[20:5];
            out_row <= cur.row;
            out_col <= cur.col;
            frame_done <= cur.done;
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- sv/rgm_checker.sv -----
`timescale 1ns / 1ps
module rgm_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic [16:0] magnitude,
  input logic [9:0] out_col,
  input logic frame_done
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(magnitude) && $stable(frame_done))
    else $error("stalled result changed");
  a_mag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> magnitude <= 17'd92320)
    else $error("magnitude out of range");
  a_col: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_col <= 10'd1021)
    else $error("column out of range");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("back to back results");
endmodule

bind rgb_gradient_magnitude_orientation rgm_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .magnitude, .out_col, .frame_done
);

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  // Upper bound on the run, with a wide margin over a correct run.
  localparam int CycleLimit = 2000000;
  // Cycles to let pass after the last expected result before touching the
  // registers or ending the run.
  localparam int DrainCycles = 60;
  localparam int RandomItems = 400;
  localparam int LineDepth = 1024;
  localparam int HeightCap = 4095;
  localparam int AngleSteps = 18;
  localparam longint QuarterTurn = 524288;
  localparam longint ArcTable [AngleSteps] = '{
    262144, 154753, 81767, 41506, 20834, 10427, 5215, 2608, 1304,
    652, 326, 163, 81, 41, 20, 10, 5, 3
  };

  // One gradient result as it leaves the block.
  typedef struct {
    logic [16:0] mag;
    logic [15:0] ang;
    logic [11:0] row;
    logic [9:0] col;
    logic done;
  } grad_result_t;

  // One row of the directed stimulus. Where typed is set, the magnitude
  // and angle of the result caused by this pixel are given by hand.
  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic typed;
    logic [16:0] mag;
    logic [15:0] ang;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [11:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] red = '0;
  logic [7:0] green = '0;
  logic [7:0] blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [16:0] magnitude;
  logic signed [15:0] angle;
  logic [11:0] out_row;
  logic [9:0] out_col;
  logic frame_done;

  rgb_gradient_magnitude_orientation i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .red(red),
    .green(green),
    .blue(blue),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .magnitude(magnitude),
    .angle(angle),
    .out_row(out_row),
    .out_col(out_col),
    .frame_done(frame_done)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the block state that the gradient predictor works on.
  logic [15:0] older_line [LineDepth];
  logic [15:0] newer_line [LineDepth];
  logic [15:0] cur_delay0, cur_delay1, old_delay0, old_delay1;
  int unsigned row_pos, col_pos;
  logic [10:0] width_reg;
  logic [11:0] height_reg;

  // Gradients that the block still owes, oldest first.
  grad_result_t pending_grads[$];

  int errors = 0;
  int cycles = 0;
  int pixels_sent = 0;
  int grads_checked = 0;
  int images_done = 0;
  bit quiet_phase = 1'b0;
  logic [7:0] last_r, last_g, last_b;

  localparam pixel_row_t WH = '{8'd255, 8'd255, 8'd255, 1'b0, 17'd0, 16'd0};
  localparam pixel_row_t BK = '{8'd0, 8'd0, 8'd0, 1'b0, 17'd0, 16'd0};

  // Three 3x3 images, one result each on the ninth pixel. The first has a
  // purely vertical gradient pointing down the rows, the second the same
  // gradient reversed (angle wraps to the negative limit), and the third a
  // purely horizontal gradient with negative dx.
  pixel_row_t directed_pixels [27] = '{
    WH, BK, WH, BK, BK, BK, BK, BK,
    '{8'd0, 8'd0, 8'd0, 1'b1, 17'd65280, 16'h0000},
    BK, BK, BK, BK, BK, BK, WH, BK,
    '{8'd0, 8'd0, 8'd0, 1'b1, 17'd65280, 16'h8000},
    WH, BK, BK, BK, BK, BK, WH, BK,
    '{8'd0, 8'd0, 8'd0, 1'b1, 17'd65280, 16'hC000}
  };

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC on (dy, dx), both scaled by 256. The accumulator is in
  // units where pi is 2^20, and the result is rounded to a scale where 2^15 = pi.
  function automatic logic [15:0] gradient_angle(longint dx, longint dy);
    longint x, y, acc, nx, sx, sy;
    if (dx == 0) return (dy >= 0) ? 16'h0000 : 16'h8000;
    if (dy == 0) return (dx > 0) ? 16'h4000 : 16'hC000;
    x = dy * 256;
    y = dx * 256;
    acc = 0;
    // A vector in the left half plane is first turned by a quarter turn.
    if (x < 0) begin
      if (y >= 0) begin
        nx = y; y = -x; x = nx; acc = QuarterTurn;
      end else begin
        nx = -y; y = x; x = nx; acc = -QuarterTurn;
      end
    end
    for (int k = 0; k < AngleSteps; k++) begin
      sx = x >>> k;
      sy = y >>> k;
      if (y >= 0) begin
        x = x + sy; y = y - sx; acc = acc + ArcTable[k];
      end else begin
        x = x - sy; y = y + sx; acc = acc - ArcTable[k];
      end
    end
    acc = (acc + 16) >>> 5;
    return acc[15:0];
  endfunction

  // Advance the shadow state by one pixel. Returns 1 and fills grad when
  // the pixel completes a 3x3 neighborhood.
  function automatic bit predict_gradient(logic [7:0] r, logic [7:0] g,
                                          logic [7:0] b,
                                          output grad_result_t grad);
    int unsigned w, h, row, col;
    logic [15:0] gray, old_val, mid_val;
    longint base, dx, dy;
    bit made;
    w = width_reg;
    h = height_reg;
    row = row_pos;
    col = col_pos;
    made = 1'b0;
    grad = '{default: '0};
    if (w < 3) w = 3;
    if (w > LineDepth) w = LineDepth;
    if (h < 3) h = 3;
    if (h > HeightCap) h = HeightCap;
    // A width or height narrowed mid-image ends the row or the image.
    if (col >= w) begin
      col = 0;
      row++;
    end
    if (row >= h) row = 0;
    gray = 16'(77 * r + 150 * g + 29 * b);
    old_val = older_line[col];
    mid_val = newer_line[col];
    if (row >= 2 && col >= 2) begin
      base = longint'(old_delay1);
      dx = longint'(old_val) - base;
      dy = base - longint'(cur_delay1);
      grad.mag = 17'(int_sqrt(longint'(dx * dx + dy * dy)));
      grad.ang = gradient_angle(dx, dy);
      grad.row = 12'(row - 2);
      grad.col = 10'(col - 2);
      grad.done = (row == h - 1) && (col == w - 1);
      made = 1'b1;
    end
    older_line[col] = mid_val;
    newer_line[col] = gray;
    old_delay1 = old_delay0;
    old_delay0 = old_val;
    cur_delay1 = cur_delay0;
    cur_delay0 = gray;
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    row_pos = row;
    col_pos = col;
    return made;
  endfunction

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (quiet_phase) return 0;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Write one register. The write takes effect at the next rising edge.
  task automatic write_reg(logic [0:0] idx, logic [11:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == 1'(rgm_pkg::RegWidth)) width_reg = value[10:0];
    else height_reg = value;
  endtask

  // Present one pixel and hold it until the block takes it. The valid is
  // left high afterwards so that back-to-back items need no toggling.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic typed, logic [16:0] tmag,
                            logic [15:0] tang);
    int gap;
    grad_result_t grad;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    red <= r;
    green <= g;
    blue <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
    last_r = r;
    last_g = g;
    last_b = b;
    if (predict_gradient(r, g, b, grad)) begin
      if (typed) begin
        grad.mag = tmag;
        grad.ang = tang;
      end
      pending_grads.insert(pending_grads.size(), grad);
      if (grad.done) images_done++;
    end
  endtask

  // Random pixels lean toward black, white and repeats so that flat areas
  // and axis-aligned gradients show up often.
  task automatic send_random_pixel();
    int roll;
    logic [7:0] shade;
    roll = $urandom_range(99);
    if (roll < 35) begin
      shade = ($urandom_range(1) == 1) ? 8'd255 : 8'd0;
      send_pixel(shade, shade, shade, 1'b0, '0, '0);
    end else if (roll < 45) begin
      send_pixel(last_r, last_g, last_b, 1'b0, '0, '0);
    end else begin
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0, '0);
    end
  endtask

  // Feed pixels until the predictor says the image has just wrapped.
  task automatic finish_image();
    do send_random_pixel(); while (!(row_pos == 0 && col_pos == 0));
  endtask

  // Drop the valid, wait for every owed result, then let the pipeline
  // settle so that nothing is in flight.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    quiet_phase = ($urandom_range(4) == 0);
  endtask

  // The output side stalls in runs of random length, mostly short.
  int stall_hold = 0;
  always @(posedge clk) begin
    bit stall_now;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_now = !quiet_phase && ($urandom_range(99) < 30);
      out_stall <= stall_now;
      if ($urandom_range(99) < 92) stall_hold <= $urandom_range(3, 0);
      else stall_hold <= $urandom_range(60, 10);
    end
  end

  // Each accepted result is matched against the oldest owed gradient.
  always @(posedge clk) begin
    grad_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_grads.size() == 0) begin
        $error("gradient result with none owed: row %0d col %0d", out_row, out_col);
        errors++;
      end else begin
        want = pending_grads.pop_front();
        grads_checked++;
        if (magnitude !== want.mag) begin
          $error("magnitude: expected %0d, got %0d", want.mag, magnitude);
          errors++;
        end
        if (angle !== want.ang) begin
          $error("angle: expected %0d, got %0d", $signed(want.ang), angle);
          errors++;
        end
        if (out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_row);
          errors++;
        end
        if (out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, out_col);
          errors++;
        end
        if (frame_done !== want.done) begin
          $error("frame_done: expected %0d, got %0d", want.done, frame_done);
          errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int target;
    int w, h;
    for (int i = 0; i < LineDepth; i++) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    cur_delay0 = '0;
    cur_delay1 = '0;
    old_delay0 = '0;
    old_delay1 = '0;
    row_pos = 0;
    col_pos = 0;
    width_reg = 11'd1024;
    height_reg = 12'd480;
    last_r = '0;
    last_g = '0;
    last_b = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Smallest legal image size first, then the directed table in it.
    write_reg(1'(rgm_pkg::RegWidth), 12'd3);
    write_reg(1'(rgm_pkg::RegHeight), 12'd3);
    foreach (directed_pixels[i]) begin
      send_pixel(directed_pixels[i].r, directed_pixels[i].g, directed_pixels[i].b,
                 directed_pixels[i].typed, directed_pixels[i].mag,
                 directed_pixels[i].ang);
    end
    drain();

    // Width below range clamps to 3 and the tallest image is started. The
    // height is then cut mid-image, which sends the counters back to row 0.
    write_reg(1'(rgm_pkg::RegWidth), 12'd1);
    write_reg(1'(rgm_pkg::RegHeight), 12'd4095);
    repeat (3 * 40) send_random_pixel();
    drain();
    write_reg(1'(rgm_pkg::RegHeight), 12'd5);
    finish_image();
    drain();

    // Width above range clamps to the line store depth, height below range
    // clamps to 3. Once row 1 is under way the width is narrowed mid-row.
    write_reg(1'(rgm_pkg::RegWidth), 12'd2047);
    write_reg(1'(rgm_pkg::RegHeight), 12'd0);
    repeat (LineDepth + 40) send_random_pixel();
    drain();
    write_reg(1'(rgm_pkg::RegWidth), 12'd50);
    finish_image();
    drain();

    // Whole images of random small sizes, written only at image boundaries
    // so the line stores never hand out stale entries.
    target = pixels_sent + RandomItems;
    while (pixels_sent < target) begin
      if ($urandom_range(9) == 0) begin
        w = $urandom_range(2, 0);
        h = $urandom_range(4, 0);
      end else begin
        w = ($urandom_range(5) == 0) ? $urandom_range(64, 3) : $urandom_range(12, 3);
        h = $urandom_range(8, 3);
      end
      write_reg(1'(rgm_pkg::RegWidth), 12'(w));
      write_reg(1'(rgm_pkg::RegHeight), 12'(h));
      finish_image();
      drain();
    end

    drain();
    if (pending_grads.size() != 0) begin
      $error("%0d gradient results never arrived", pending_grads.size());
      errors++;
    end
    $display("Sent %0d pixels over %0d complete images; %0d gradients checked.",
             pixels_sent, images_done, grads_checked);
    $display("Covered clamped sizes, the tallest and widest images, and mid-image cuts.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ----- rgb_gradient_magnitude_orientation.f -----
sv/rgm_pkg.sv
sv/rgm_front.sv
sv/rgm_back.sv
sv/rgb_gradient_magnitude_orientation.sv
sv/rgm_checker.sv
verif/testbench.sv
